// ===== design/section_rva_to_file_offset_defines.svh =====
// Assertion macros shared by the section translator RTL.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef SECTION_RVA_TO_FILE_OFFSET_DEFINES_SVH
`define SECTION_RVA_TO_FILE_OFFSET_DEFINES_SVH

// same-cycle implication
`define SRTFO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRTFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/srtfo_pkg.sv =====
// Types and codes for the section table address translator.
// No dependencies.
package srtfo_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  localparam logic [1:0] CFG_SECTION_COUNT = 2'd0;
  localparam logic [1:0] CFG_SECTION_ALIGN = 2'd1;
  localparam logic [1:0] CFG_FILE_ALIGN    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HEAD,
    ST_CHECK,
    ST_RND_V,
    ST_RND_P,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [31:0] virt_addr;
    logic [31:0] virt_size;
    logic [31:0] raw_size;
    logic [31:0] raw_ptr;
  } sect_t;

  // request to the shared round-up unit
  typedef struct packed {
    logic        go;
    logic [31:0] value;
    logic [31:0] grain;
  } rnd_req_t;

endpackage

// ===== design/section_rva_to_file_offset.sv =====
// Top level of the section table address translator.
// Uses srtfo_pkg, srtfo_round and section_rva_to_file_offset_defines.svh.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  command   | start / busy     | cmd, entry_index, sect_*, rva, span_size
//  result    | done (strobe)    | file_pos, found
//  config    | cfg_we           | cfg_index, cfg_data
//
// A load writes one table entry and leaves the block idle. A translate fetches
// the first entry for the head check, which may settle it. Each entry walked is
// then checked and either skipped or has its sizes rounded (check, two passes of
// the shared round-up unit, decide); each entry after the first is fetched first.
// Reset is synchronous; table contents are not cleared. The result strobe
// lasts one cycle and cannot be held off; busy is low again in that cycle.
`include "section_rva_to_file_offset_defines.svh"

module section_rva_to_file_offset #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [3:0]  entry_index,
  input  logic [31:0] sect_virt_addr,
  input  logic [31:0] sect_virt_size,
  input  logic [31:0] sect_raw_size,
  input  logic [31:0] sect_raw_ptr,
  input  logic [31:0] rva,
  input  logic [31:0] span_size,
  output logic        done,
  output logic [31:0] file_pos,
  output logic        found,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

  srtfo_pkg::state_t   state, state_next;
  srtfo_pkg::sect_t    tab [MAX_SECTIONS];
  srtfo_pkg::sect_t    rd_q;
  srtfo_pkg::rnd_req_t rnd_req;

  logic [4:0]       section_count;
  logic [31:0]      section_alignment;
  logic [31:0]      file_alignment;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] n_eff;
  logic             head, head_next;
  logic [31:0]      addr, span;
  logic [31:0]      vs_r, vs_r_next;
  logic [31:0]      ps_r, ps_r_next;
  logic             done_next, found_next;
  logic [31:0]      file_pos_next;
  logic             rnd_done;
  logic [31:0]      rnd_result;
  logic             accept;
  logic [31:0]      lim0, off, lim;

  assign accept = start && !busy;
  assign busy   = (state != srtfo_pkg::ST_IDLE);

  // count saturated to the table size
  assign n_eff = (32'(section_count) > 32'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                          : CNT_W'(section_count);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      section_count     <= 5'd0;
      section_alignment <= 32'd4096;
      file_alignment    <= 32'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        srtfo_pkg::CFG_SECTION_COUNT: section_count     <= cfg_data[4:0];
        srtfo_pkg::CFG_SECTION_ALIGN: section_alignment <= cfg_data;
        srtfo_pkg::CFG_FILE_ALIGN:    file_alignment    <= cfg_data;
        default: ;
      endcase
    end
  end

  // section table: one write port, registered read
  always_ff @(posedge clk) begin
    if (accept && cmd == srtfo_pkg::CMD_LOAD &&
        32'(entry_index) < 32'(MAX_SECTIONS)) begin
      tab[IDX_W'(entry_index)] <= '{sect_virt_addr, sect_virt_size,
                                    sect_raw_size, sect_raw_ptr};
    end
    rd_q <= tab[idx[IDX_W-1:0]];
  end

  // latch the transaction operands
  always_ff @(posedge clk) begin
    if (accept) begin
      addr <= rva;
      span <= span_size;
    end
  end

  srtfo_round u_round (
    .clk    (clk),
    .rst    (rst),
    .req    (rnd_req),
    .done   (rnd_done),
    .result (rnd_result)
  );

  assign lim0 = (rd_q.virt_addr < rd_q.raw_ptr) ? rd_q.virt_addr : rd_q.raw_ptr;
  assign off  = addr - rd_q.virt_addr;
  assign lim  = (vs_r < ps_r) ? vs_r : ps_r;

  // sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    head_next     = head;
    vs_r_next     = vs_r;
    ps_r_next     = ps_r;
    done_next     = 1'b0;
    found_next    = 1'b0;
    file_pos_next = file_pos;
    rnd_req       = '{go: 1'b0, value: rd_q.raw_size, grain: file_alignment};
    case (state)
      srtfo_pkg::ST_IDLE: begin
        if (accept && cmd == srtfo_pkg::CMD_XLATE) begin
          if (n_eff == '0) begin
            done_next     = 1'b1;
            file_pos_next = 32'd0;
          end else begin
            idx_next   = '0;
            head_next  = 1'b1;
            state_next = srtfo_pkg::ST_FETCH;
          end
        end
      end
      srtfo_pkg::ST_FETCH: begin
        state_next = head ? srtfo_pkg::ST_HEAD : srtfo_pkg::ST_CHECK;
      end
      srtfo_pkg::ST_HEAD: begin
        head_next = 1'b0;
        if (addr < lim0) begin
          done_next     = 1'b1;
          found_next    = (span <= lim0 - addr);
          file_pos_next = (span <= lim0 - addr) ? addr : 32'd0;
          state_next    = srtfo_pkg::ST_IDLE;
        end else begin
          state_next = srtfo_pkg::ST_CHECK;
        end
      end
      srtfo_pkg::ST_CHECK: begin
        if (rd_q.raw_ptr == 32'd0 || addr < rd_q.virt_addr) begin
          if (idx + CNT_W'(1) == n_eff) begin
            done_next     = 1'b1;
            file_pos_next = 32'd0;
            state_next    = srtfo_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = srtfo_pkg::ST_FETCH;
          end
        end else begin
          rnd_req = '{go: 1'b1,
                      value: (rd_q.virt_size == 32'd0) ? rd_q.raw_size : rd_q.virt_size,
                      grain: section_alignment};
          state_next = srtfo_pkg::ST_RND_V;
        end
      end
      srtfo_pkg::ST_RND_V: begin
        if (rnd_done) begin
          vs_r_next  = rnd_result;
          rnd_req.go = 1'b1;
          state_next = srtfo_pkg::ST_RND_P;
        end
      end
      srtfo_pkg::ST_RND_P: begin
        if (rnd_done) begin
          ps_r_next  = rnd_result;
          state_next = srtfo_pkg::ST_DECIDE;
        end
      end
      srtfo_pkg::ST_DECIDE: begin
        if (off < lim) begin
          done_next     = 1'b1;
          found_next    = (span <= lim - off);
          file_pos_next = (span <= lim - off) ? rd_q.raw_ptr + off : 32'd0;
          state_next    = srtfo_pkg::ST_IDLE;
        end else if (idx + CNT_W'(1) == n_eff) begin
          done_next     = 1'b1;
          file_pos_next = 32'd0;
          state_next    = srtfo_pkg::ST_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = srtfo_pkg::ST_FETCH;
        end
      end
      default: state_next = srtfo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtfo_pkg::ST_IDLE;
      idx   <= '0;
      head  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      head  <= head_next;
      done  <= done_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    vs_r     <= vs_r_next;
    ps_r     <= ps_r_next;
    file_pos <= file_pos_next;
  end

  // checks
  `SRTFO_ASSERT_NEXT(a_xlate_busy, accept && cmd == srtfo_pkg::CMD_XLATE && n_eff != '0, busy, "translate did not start")
  `SRTFO_ASSERT_NEXT(a_load_quiet, accept && cmd == srtfo_pkg::CMD_LOAD, !busy && !done, "load gave a result")
  `SRTFO_ASSERT_NOW(a_done_idle, done, !busy, "result while still busy")
  `SRTFO_ASSERT_NOW(a_found_strobe, !done, !found, "found without result strobe")

endmodule

// ===== design/srtfo_round.sv =====
// Round-up unit: value rounded up to a multiple of grain, 32-bit wrap.
// Restoring remainder, one bit per cycle. Uses srtfo_pkg.
module srtfo_round (
  input  logic                 clk,
  input  logic                 rst,
  input  srtfo_pkg::rnd_req_t  req,
  output logic                 done,
  output logic [31:0]          result
);

  logic [31:0] t_orig;
  logic [31:0] t_sh;
  logic [31:0] grain;
  logic [31:0] value;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        active;
  logic [32:0] shifted;
  logic        take;

  // one remainder step
  assign shifted = {rem, t_sh[31]};
  assign take    = shifted >= {1'b0, grain};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= 6'd32;
      end else if (active) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      t_orig <= req.value + req.grain - 32'd1;
      t_sh   <= req.value + req.grain - 32'd1;
      grain  <= req.grain;
      value  <= req.value;
      rem    <= 32'd0;
    end else if (active) begin
      t_sh <= {t_sh[30:0], 1'b0};
      rem  <= take ? 32'(shifted - {1'b0, grain}) : shifted[31:0];
    end
  end

  // zero grain leaves the value unrounded
  assign result = (grain == 32'd0) ? value : t_orig - rem;

endmodule
